>>> rtl/scpa_pkg.sv
// ----------------------------------------------------------------------------
// Size-class pool allocator package
// Shared constants, codes, descriptor layout and the size-class lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package scpa_pkg;

  localparam int unsigned MAX_POOL_BYTES = 16384;
  localparam int unsigned NUM_CLASSES    = 7;
  localparam int unsigned HEADER_BYTES   = 64;
  localparam int unsigned DESC_BYTES     = 16;

  // Fixed field widths of the interface.
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned OFF_W   = 14;
  localparam int unsigned CLS_W   = 3;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_REGS  = 8;

  // Descriptor store: one entry per 32-bit word of the pool.
  localparam int unsigned DESC_DEPTH = MAX_POOL_BYTES / 4;
  localparam int unsigned IDX_W      = $clog2(DESC_DEPTH);

  localparam logic [SIZE_W-1:0] SIZE_MASK = 15'h7ffc;

  // Request types; any other code is handled as an info request.
  localparam logic [REQ_W-1:0] REQ_GET = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT = 2'd1;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 3'd0;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_TOO_LARGE   = 3'd1,
    ST_NO_ROOM     = 3'd2,
    ST_NOT_IN_POOL = 3'd3,
    ST_BAD_DESC    = 3'd4
  } status_e;

  localparam logic [1:0] TAG_UNUSED    = 2'd0;
  localparam logic [1:0] TAG_ALLOCATED = 2'd1;
  localparam logic [1:0] TAG_FREED     = 2'd2;

  typedef struct packed {
    logic [1:0]        tag;
    logic [SIZE_W-1:0] size;
    logic              next_ok;
    logic [IDX_W-1:0]  next;
  } desc_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    desc_t            data;
  } desc_wr_t;

  typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0] class_sizes_t;

  typedef struct packed {
    logic             ok;
    logic [CLS_W-1:0] idx;
  } cls_res_t;

  // Smallest class that holds the size, classes listed largest first.
  function automatic cls_res_t find_class(input logic [SIZE_W-1:0] size,
                                          input class_sizes_t     sizes);
    cls_res_t res;
    logic     stop;
    res.ok  = (size <= sizes[0]);
    res.idx = '0;
    stop    = 1'b0;
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (!stop && (size <= sizes[i])) begin
        res.idx = CLS_W'(i);
      end else begin
        stop = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/size_class_pool_allocator_top.sv
// An accepted request passes the look, class and execute states; its result is
// registered once the output register is free or being read. A new request is
// taken only in the idle state: the descriptor store read, the class lookup on
// the read data and the write-back run one after another. Reset: asynchronous,
// active low. A clearing pass then marks every descriptor unused; no request is
// accepted until it ends. Configuration writes are accepted in every cycle.
// ----------------------------------------------------------------------------
// Size-class pool allocator, top level
// Segregated LIFO free lists with a bump-pointer carver and a descriptor store.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_pool_allocator_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [scpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [scpa_pkg::SIZE_W-1:0]      cfg_data_i,
  // Requests
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [scpa_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [scpa_pkg::SIZE_W-1:0]      req_size_i,
  input  wire logic [scpa_pkg::OFF_W-1:0]       buffer_offset_i,
  // Results
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [scpa_pkg::STAT_W-1:0]           status_o,
  output logic [scpa_pkg::SIZE_W-1:0]           block_size_o,
  output logic [scpa_pkg::OFF_W-1:0]            granted_offset_o,
  output logic [scpa_pkg::CLS_W-1:0]            class_index_o,
  output logic [scpa_pkg::CNT_W-1:0]            class_free_count_o,
  output logic [scpa_pkg::CNT_W-1:0]            class_created_count_o,
  output logic [scpa_pkg::SIZE_W-1:0]           free_bytes_o,
  output logic [scpa_pkg::TOT_W-1:0]            blocks_carved_o,
  output logic [scpa_pkg::TOT_W-1:0]            check_errors_o
);

  localparam int unsigned NC    = scpa_pkg::NUM_CLASSES;
  localparam int unsigned SW    = scpa_pkg::SIZE_W;
  localparam int unsigned IW    = scpa_pkg::IDX_W;
  localparam int unsigned CW    = scpa_pkg::CNT_W;
  localparam int unsigned SUM_W = SW + 2;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_CLASS = 5'b01000,
    S_EXEC  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [SW-1:0]          end_q;
  scpa_pkg::class_sizes_t csize_q;

  // Class state
  logic [IW-1:0] class_top_q     [NC];
  logic          class_top_ok_q  [NC];
  logic [CW-1:0] class_free_q    [NC];
  logic [CW-1:0] class_created_q [NC];
  logic [SW-1:0]                 bump_q;
  logic [scpa_pkg::TOT_W-1:0]    carved_q;
  logic [scpa_pkg::TOT_W-1:0]    errors_q;

  // Request in flight
  logic                          is_get_q, is_put_q;
  logic [scpa_pkg::OFF_W-1:0]    off_q;
  logic [scpa_pkg::CLS_W-1:0]    cls_q;
  logic                          cls_ok_q;
  logic                          nip_q, misal_q;
  logic [IW-1:0]                 didx_q;
  logic [IW-1:0]                 clr_q;

  // Memory
  scpa_pkg::desc_wr_t wr;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  scpa_pkg::desc_t    rd;

  // Output register
  logic                          out_valid_q;
  logic [scpa_pkg::STAT_W-1:0]   status_q;
  logic [SW-1:0]                 bsize_q;
  logic [scpa_pkg::OFF_W-1:0]    granted_q;
  logic [scpa_pkg::CLS_W-1:0]    cls_out_q;
  logic [CW-1:0]                 free_cnt_q, created_cnt_q;
  logic [SW-1:0]                 free_bytes_q;
  logic [scpa_pkg::TOT_W-1:0]    carved_out_q, errors_out_q;

  logic in_acc, exec_go;
  scpa_pkg::cls_res_t fc_in, fc_rd;

  // Look stage
  logic                       look_nip;
  logic [scpa_pkg::OFF_W-1:0] look_bd;

  // Execute stage
  scpa_pkg::status_e     ex_status;
  logic [SW-1:0]         ex_bsize;
  logic [scpa_pkg::OFF_W-1:0] ex_granted;
  logic                  ex_cls_hit;
  logic [SW-1:0]         blk;
  logic [SUM_W-1:0]      carve_sum;
  logic                  top_we, top_ok_new, free_we, created_we;
  logic [IW-1:0]         top_new;
  logic [CW-1:0]         free_new, created_new;
  logic [SW-1:0]         bump_d;
  logic [scpa_pkg::TOT_W-1:0] carved_d, errors_d;
  logic [SW-1:0]         free_bytes_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign exec_go     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign fc_in = scpa_pkg::find_class(req_size_i, csize_q);
  assign fc_rd = scpa_pkg::find_class(rd.size, csize_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (&clr_q) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_LOOK;
      S_LOOK:  state_d = S_CLASS;
      S_CLASS: state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Range check for put and info; the descriptor sits just below the buffer.
  assign look_nip = (off_q < scpa_pkg::OFF_W'(scpa_pkg::DESC_BYTES)) ||
                    ({1'b0, off_q} >= end_q);
  assign look_bd  = off_q - scpa_pkg::OFF_W'(scpa_pkg::DESC_BYTES);

  assign mem_re    = (state_q == S_LOOK);
  assign mem_raddr = is_get_q ? class_top_q[cls_q] : look_bd[scpa_pkg::OFF_W-1:2];

  // Execute stage: decide the outcome from the read descriptor and class state.
  assign blk       = csize_q[cls_q];
  assign carve_sum = SUM_W'(bump_q) + SUM_W'(scpa_pkg::DESC_BYTES) + SUM_W'(blk);

  always_comb begin
    ex_status   = scpa_pkg::ST_OK;
    ex_bsize    = '0;
    ex_granted  = '0;
    ex_cls_hit  = 1'b0;
    wr          = '0;
    top_we      = 1'b0;
    top_new     = class_top_q[cls_q];
    top_ok_new  = class_top_ok_q[cls_q];
    free_we     = 1'b0;
    free_new    = class_free_q[cls_q];
    created_we  = 1'b0;
    created_new = class_created_q[cls_q];
    bump_d      = bump_q;
    carved_d    = carved_q;
    errors_d    = errors_q;

    if (is_get_q) begin
      if (!cls_ok_q) begin
        ex_status = scpa_pkg::ST_TOO_LARGE;
      end else if (class_top_ok_q[cls_q]) begin
        // Pop the head of the free list; its next link was just read.
        ex_cls_hit       = 1'b1;
        wr.we            = 1'b1;
        wr.addr          = class_top_q[cls_q];
        wr.data.tag      = scpa_pkg::TAG_ALLOCATED;
        wr.data.size     = blk;
        top_we           = 1'b1;
        top_new          = rd.next;
        top_ok_new       = rd.next_ok;
        free_we          = 1'b1;
        free_new         = class_free_q[cls_q] - CW'(1);
        ex_granted       = {class_top_q[cls_q], 2'b00} +
                           scpa_pkg::OFF_W'(scpa_pkg::DESC_BYTES);
        ex_bsize         = blk;
      end else if (carve_sum >= SUM_W'(end_q)) begin
        ex_status = scpa_pkg::ST_NO_ROOM;
      end else begin
        ex_cls_hit   = 1'b1;
        wr.we        = 1'b1;
        wr.addr      = bump_q[IW+1:2];
        wr.data.tag  = scpa_pkg::TAG_ALLOCATED;
        wr.data.size = blk;
        created_we   = 1'b1;
        created_new  = class_created_q[cls_q] + CW'(1);
        carved_d     = carved_q + scpa_pkg::TOT_W'(1);
        ex_granted   = scpa_pkg::OFF_W'(bump_q) + scpa_pkg::OFF_W'(scpa_pkg::DESC_BYTES);
        bump_d       = carve_sum[SW-1:0];
        ex_bsize     = blk;
      end
    end else begin
      if (nip_q) begin
        ex_status = scpa_pkg::ST_NOT_IN_POOL;
      end else if (misal_q || (rd.tag != scpa_pkg::TAG_ALLOCATED)) begin
        ex_status = scpa_pkg::ST_BAD_DESC;
        if (is_put_q) errors_d = errors_q + scpa_pkg::TOT_W'(1);
      end else if (!is_put_q) begin
        ex_bsize = rd.size;
      end else if (!cls_ok_q) begin
        ex_status = scpa_pkg::ST_BAD_DESC;
        errors_d  = errors_q + scpa_pkg::TOT_W'(1);
      end else begin
        // Push the block onto its class list.
        ex_cls_hit      = 1'b1;
        wr.we           = 1'b1;
        wr.addr         = didx_q;
        wr.data.tag     = scpa_pkg::TAG_FREED;
        wr.data.size    = rd.size;
        wr.data.next    = class_top_q[cls_q];
        wr.data.next_ok = class_top_ok_q[cls_q];
        top_we          = 1'b1;
        top_new         = didx_q;
        top_ok_new      = 1'b1;
        free_we         = 1'b1;
        free_new        = class_free_q[cls_q] + CW'(1);
        ex_bsize        = blk;
      end
    end

    free_bytes_d = (end_q > bump_d) ? (end_q - bump_d) : '0;

    if (state_q == S_CLEAR) begin
      wr      = '0;
      wr.we   = 1'b1;
      wr.addr = clr_q;
    end else if (!exec_go) begin
      wr.we = 1'b0;
    end
  end

  scpa_desc_ram u_desc_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  // Control, configuration and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      end_q       <= SW'(scpa_pkg::MAX_POOL_BYTES);
      for (int i = 0; i < NC; i++) begin
        csize_q[i]         <= (i < 7) ? SW'(1024 >> i) : '0;
        class_top_q[i]     <= '0;
        class_top_ok_q[i]  <= 1'b0;
        class_free_q[i]    <= '0;
        class_created_q[i] <= '0;
      end
      bump_q   <= SW'(scpa_pkg::HEADER_BYTES);
      carved_q <= '0;
      errors_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + IW'(1);

      if (cfg_valid_i) begin
        if (cfg_index_i == scpa_pkg::CFG_POOL_BYTES) begin
          end_q <= ((cfg_data_i & scpa_pkg::SIZE_MASK) > SW'(scpa_pkg::MAX_POOL_BYTES)) ?
                   SW'(scpa_pkg::MAX_POOL_BYTES) : (cfg_data_i & scpa_pkg::SIZE_MASK);
        end
        for (int i = 0; i < NC; i++) begin
          if ((i + 1 < scpa_pkg::NUM_REGS) &&
              (cfg_index_i == scpa_pkg::CFG_IDX_W'(i + 1))) begin
            csize_q[i] <= cfg_data_i & scpa_pkg::SIZE_MASK;
          end
        end
      end

      if (exec_go) begin
        if (top_we) begin
          class_top_q[cls_q]    <= top_new;
          class_top_ok_q[cls_q] <= top_ok_new;
        end
        if (free_we)    class_free_q[cls_q]    <= free_new;
        if (created_we) class_created_q[cls_q] <= created_new;
        bump_q   <= bump_d;
        carved_q <= carved_d;
        errors_q <= errors_d;
      end

      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_get_q <= (req_type_i == scpa_pkg::REQ_GET);
      is_put_q <= (req_type_i == scpa_pkg::REQ_PUT);
      off_q    <= buffer_offset_i;
      cls_q    <= fc_in.idx;
      cls_ok_q <= fc_in.ok;
    end
    if (state_q == S_LOOK) begin
      nip_q   <= look_nip;
      misal_q <= (look_bd[1:0] != 2'b00);
      didx_q  <= look_bd[scpa_pkg::OFF_W-1:2];
    end
    // A put takes its class from the stored block size.
    if ((state_q == S_CLASS) && is_put_q) begin
      cls_q    <= fc_rd.idx;
      cls_ok_q <= fc_rd.ok;
    end
    if (exec_go) begin
      status_q      <= ex_status;
      bsize_q       <= ex_bsize;
      granted_q     <= ex_granted;
      cls_out_q     <= ex_cls_hit ? cls_q : '0;
      free_cnt_q    <= ex_cls_hit ? free_new : '0;
      created_cnt_q <= ex_cls_hit ? created_new : '0;
      free_bytes_q  <= free_bytes_d;
      carved_out_q  <= carved_d;
      errors_out_q  <= errors_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign block_size_o          = bsize_q;
  assign granted_offset_o      = granted_q;
  assign class_index_o         = cls_out_q;
  assign class_free_count_o    = free_cnt_q;
  assign class_created_count_o = created_cnt_q;
  assign free_bytes_o          = free_bytes_q;
  assign blocks_carved_o       = carved_out_q;
  assign check_errors_o        = errors_out_q;

endmodule

`default_nettype wire

>>> rtl/scpa_desc_ram.sv
// ----------------------------------------------------------------------------
// Descriptor store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scpa_desc_ram (
  input  wire logic                       clk_i,
  input  wire scpa_pkg::desc_wr_t         wr_i,
  input  wire logic                       re_i,
  input  wire logic [scpa_pkg::IDX_W-1:0] raddr_i,
  output scpa_pkg::desc_t                 rdata_o
);

  scpa_pkg::desc_t mem_q [scpa_pkg::DESC_DEPTH];
  scpa_pkg::desc_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/scpa_checker.sv
// ----------------------------------------------------------------------------
// Size-class pool allocator port checker
// Watches the top-level ports and flags behaviour the design never shows.
// ----------------------------------------------------------------------------
`default_nettype none

module scpa_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [scpa_pkg::STAT_W-1:0]    status_o,
  input wire logic [scpa_pkg::SIZE_W-1:0]    block_size_o,
  input wire logic [scpa_pkg::OFF_W-1:0]     granted_offset_o,
  input wire logic [scpa_pkg::CLS_W-1:0]     class_index_o
);

  // A result not taken stays offered, its status and granted offset unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
                                    $stable(granted_offset_o))
    else $error("result dropped or changed while stalled");

  // One request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // A failed request reports no block and no class.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != scpa_pkg::ST_OK) |->
      (block_size_o == '0) && (granted_offset_o == '0) && (class_index_o == '0))
    else $error("error result carries block fields");

  // Granted buffers are always word aligned.
  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (granted_offset_o[1:0] == 2'b00))
    else $error("granted offset not word aligned");

endmodule

bind size_class_pool_allocator_top scpa_checker u_scpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .block_size_o     (block_size_o),
  .granted_offset_o (granted_offset_o),
  .class_index_o    (class_index_o)
);

`default_nettype wire

>>> tb/size_class_pool_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-class pool allocator testbench
// Drives get, put and info requests through several pool and class settings,
// predicts every reply with a scoreboard that tracks the free lists, the
// descriptor tags and the bump pointer, and checks each reply field by field.
// ----------------------------------------------------------------------------

module size_class_pool_allocator_top_tb;

  import scpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_SIZE_0 = 3'd1;
  localparam logic [REQ_W-1:0]     REQ_INFO         = 2'd2;
  localparam logic [REQ_W-1:0]     REQ_INFO_ALT     = 2'd3;
  localparam int unsigned          SETTLE_CYCLES    = 8;
  localparam int unsigned          HOLD_CYCLES      = 400;

  typedef logic [0:NUM_CLASSES-1][SIZE_W-1:0] class_set_t;

  typedef struct {
    status_e           status;
    logic [SIZE_W-1:0] block_size;
    logic [OFF_W-1:0]  granted_offset;
    logic [CLS_W-1:0]  class_index;
    logic [CNT_W-1:0]  class_free;
    logic [CNT_W-1:0]  class_created;
    logic [SIZE_W-1:0] free_bytes;
    logic [TOT_W-1:0]  blocks_carved;
    logic [TOT_W-1:0]  check_errors;
  } reply_t;

  class pool_scoreboard;
    logic [1:0]        d_tag     [DESC_DEPTH];
    logic [SIZE_W-1:0] d_size    [DESC_DEPTH];
    logic              d_next_ok [DESC_DEPTH];
    logic [IDX_W-1:0]  d_next    [DESC_DEPTH];
    logic [IDX_W-1:0]  head      [NUM_CLASSES];
    logic              head_ok   [NUM_CLASSES];
    logic [CNT_W-1:0]  free_cnt  [NUM_CLASSES];
    logic [CNT_W-1:0]  made_cnt  [NUM_CLASSES];
    logic [SIZE_W-1:0] class_reg [NUM_CLASSES];
    logic [SIZE_W-1:0] pool_reg;
    int unsigned       bump;
    logic [TOT_W-1:0]  carved;
    logic [TOT_W-1:0]  rejects;
    reply_t            due_replies[$];
    int unsigned       n_fail;

    function new();
      for (int i = 0; i < DESC_DEPTH; i++) begin
        d_tag[i]     = TAG_UNUSED;
        d_size[i]    = '0;
        d_next_ok[i] = 1'b0;
        d_next[i]    = '0;
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]      = '0;
        head_ok[c]   = 1'b0;
        free_cnt[c]  = '0;
        made_cnt[c]  = '0;
        class_reg[c] = SIZE_W'(1024 >> c);
      end
      pool_reg = 15'd16384;
      bump     = HEADER_BYTES;
      carved   = '0;
      rejects  = '0;
      n_fail   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      if (idx == CFG_POOL_BYTES) begin
        pool_reg = val;
      end else begin
        class_reg[idx - CFG_CLASS_SIZE_0] = val;
      end
    endfunction

    function int unsigned pool_limit();
      int unsigned e;
      e = pool_reg & SIZE_MASK;
      return (e > MAX_POOL_BYTES) ? MAX_POOL_BYTES : e;
    endfunction

    function int unsigned class_bytes(int c);
      return class_reg[c] & SIZE_MASK;
    endfunction

    // Classes run largest first, so walk down while the next one still fits.
    function int lookup_class(int unsigned sz);
      int i;
      if (sz > class_bytes(0)) return -1;
      i = 0;
      while (i < NUM_CLASSES - 1 && sz <= class_bytes(i + 1)) i++;
      return i;
    endfunction

    function int unsigned outstanding();
      return due_replies.size();
    endfunction

    // Updates the allocator state for one accepted request and queues its reply.
    function reply_t note_request(logic [REQ_W-1:0] kind, logic [SIZE_W-1:0] size,
                                  logic [OFF_W-1:0] off);
      reply_t      rep;
      status_e     st;
      int unsigned lim, blk, idx, bd, bsz, grant;
      int          cls;
      lim   = pool_limit();
      st    = ST_OK;
      bsz   = 0;
      grant = 0;
      cls   = -1;
      if (kind == REQ_GET) begin
        cls = lookup_class(size);
        if (cls < 0) begin
          st = ST_TOO_LARGE;
        end else begin
          blk = class_bytes(cls);
          if (head_ok[cls]) begin
            idx            = head[cls];
            d_tag[idx]     = TAG_ALLOCATED;
            d_size[idx]    = SIZE_W'(blk);
            head[cls]      = d_next[idx];
            head_ok[cls]   = d_next_ok[idx];
            d_next_ok[idx] = 1'b0;
            d_next[idx]    = '0;
            free_cnt[cls]  = free_cnt[cls] - 1'b1;
            grant          = idx * 4 + DESC_BYTES;
            bsz            = blk;
          end else if (bump + DESC_BYTES + blk >= lim) begin
            st  = ST_NO_ROOM;
            cls = -1;
          end else begin
            idx            = bump >> 2;
            made_cnt[cls]  = made_cnt[cls] + 1'b1;
            carved         = carved + 1;
            d_tag[idx]     = TAG_ALLOCATED;
            d_size[idx]    = SIZE_W'(blk);
            d_next_ok[idx] = 1'b0;
            d_next[idx]    = '0;
            grant          = bump + DESC_BYTES;
            bump           = bump + DESC_BYTES + blk;
            bsz            = blk;
          end
        end
      end else if (off < DESC_BYTES || off >= lim) begin
        st = ST_NOT_IN_POOL;
      end else begin
        bd  = off - DESC_BYTES;
        idx = bd >> 2;
        if ((bd & 3) != 0 || d_tag[idx] != TAG_ALLOCATED) begin
          st = ST_BAD_DESC;
          if (kind == REQ_PUT) rejects = rejects + 1;
        end else if (kind != REQ_PUT) begin
          bsz = d_size[idx];
        end else begin
          cls = lookup_class(d_size[idx]);
          if (cls < 0) begin
            st      = ST_BAD_DESC;
            rejects = rejects + 1;
          end else begin
            d_tag[idx]     = TAG_FREED;
            d_next[idx]    = head[cls];
            d_next_ok[idx] = head_ok[cls];
            head[cls]      = IDX_W'(idx);
            head_ok[cls]   = 1'b1;
            free_cnt[cls]  = free_cnt[cls] + 1'b1;
            bsz            = class_bytes(cls);
          end
        end
      end
      rep.status         = st;
      rep.block_size     = SIZE_W'(bsz);
      rep.granted_offset = OFF_W'(grant);
      if (cls < 0) begin
        rep.class_index   = '0;
        rep.class_free    = '0;
        rep.class_created = '0;
      end else begin
        rep.class_index   = CLS_W'(cls);
        rep.class_free    = free_cnt[cls];
        rep.class_created = made_cnt[cls];
      end
      rep.free_bytes    = (lim > bump) ? SIZE_W'(lim - bump) : '0;
      rep.blocks_carved = carved;
      rep.check_errors  = rejects;
      due_replies.push_back(rep);
      return rep;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_fail++;
      if (n_fail <= 100) begin
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
    endtask

    task cmp(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_result(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        report_mismatch("unexpected reply", 32'(got.status), '0);
      end else begin
        want = due_replies.pop_front();
        cmp("status", 32'(got.status), 32'(want.status));
        cmp("block_size", 32'(got.block_size), 32'(want.block_size));
        cmp("granted_offset", 32'(got.granted_offset), 32'(want.granted_offset));
        cmp("class_index", 32'(got.class_index), 32'(want.class_index));
        cmp("class_free_count", 32'(got.class_free), 32'(want.class_free));
        cmp("class_created_count", 32'(got.class_created), 32'(want.class_created));
        cmp("free_bytes", 32'(got.free_bytes), 32'(want.free_bytes));
        cmp("blocks_carved", got.blocks_carved, want.blocks_carved);
        cmp("check_errors", got.check_errors, want.check_errors);
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SIZE_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [REQ_W-1:0]     req_type_i;
  logic [SIZE_W-1:0]    req_size_i;
  logic [OFF_W-1:0]     buffer_offset_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STAT_W-1:0]    status_o;
  logic [SIZE_W-1:0]    block_size_o;
  logic [OFF_W-1:0]     granted_offset_o;
  logic [CLS_W-1:0]     class_index_o;
  logic [CNT_W-1:0]     class_free_count_o;
  logic [CNT_W-1:0]     class_created_count_o;
  logic [SIZE_W-1:0]    free_bytes_o;
  logic [TOT_W-1:0]     blocks_carved_o;
  logic [TOT_W-1:0]     check_errors_o;

  pool_scoreboard   sb = new();
  logic [OFF_W-1:0] live_q[$];
  logic [OFF_W-1:0] freed_q[$];
  logic [SIZE_W-1:0] cur_largest = 15'd1024;
  bit               idle_en = 1'b1;
  bit               hold_req = 1'b0;

  size_class_pool_allocator_top DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .req_type_i            (req_type_i),
    .req_size_i            (req_size_i),
    .buffer_offset_i       (buffer_offset_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_o              (status_o),
    .block_size_o          (block_size_o),
    .granted_offset_o      (granted_offset_o),
    .class_index_o         (class_index_o),
    .class_free_count_o    (class_free_count_o),
    .class_created_count_o (class_created_count_o),
    .free_bytes_o          (free_bytes_o),
    .blocks_carved_o       (blocks_carved_o),
    .check_errors_o        (check_errors_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : reply_monitor
    reply_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      got.status         = status_e'(status_o);
      got.block_size     = block_size_o;
      got.granted_offset = granted_offset_o;
      got.class_index    = class_index_o;
      got.class_free     = class_free_count_o;
      got.class_created  = class_created_count_o;
      got.free_bytes     = free_bytes_o;
      got.blocks_carved  = blocks_carved_o;
      got.check_errors   = check_errors_o;
      sb.check_result(got);
    end
  end

  // Reply-side back-pressure: short random stalls, calm stretches, and one
  // long hold-off on request so that a stalled result holds off further requests.
  initial begin : reply_ready_drive
    int unsigned stall_left, calm_left, hold_left;
    stall_left  = 0;
    calm_left   = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (calm_left != 0) begin
        calm_left--;
      end else if (stall_left == 0 && idle_en) begin
        if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(40, 120);
        else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
      end
      out_ready_i <= (hold_left == 0) && (stall_left == 0);
      if (hold_left != 0) hold_left--;
      else if (stall_left != 0) stall_left--;
    end
  end

  initial begin : run_limit
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return SIZE_W'($urandom_range(0, 64));
    if (r < 80) return SIZE_W'($urandom_range(0, 1100));
    if (r < 88) return SIZE_W'($urandom_range(0, 16400));
    if (r < 95) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return cur_largest;
        2:       return cur_largest + 1'b1;
        default: return 15'h7fff;
      endcase
    end
    return SIZE_W'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SIZE_W-1:0] size,
                              input logic [OFF_W-1:0] off, output reply_t rep);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    req_size_i      <= size;
    buffer_offset_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    rep = sb.note_request(kind, size, off);
    if (rep.status == ST_OK && kind == REQ_GET) live_q.push_back(rep.granted_offset);
    if (rep.status == ST_OK && kind == REQ_PUT) begin
      freed_q.push_back(off);
      if (freed_q.size() > 16) void'(freed_q.pop_front());
    end
    @(negedge clk_i);
  endtask

  task automatic random_request();
    reply_t            rep;
    logic [REQ_W-1:0]  kind;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
    int unsigned       pick, k;
    size = SIZE_W'($urandom);
    off  = OFF_W'($urandom);
    pick = $urandom_range(0, 99);
    // Keep the number of live buffers bounded so the pool is not used up early.
    if (live_q.size() > 40 && pick < 45) pick = 60;
    if (pick < 45) begin
      kind = REQ_GET;
      size = pick_size();
    end else if (pick < 75) begin
      kind = REQ_PUT;
      if (live_q.size() != 0) begin
        k   = $urandom_range(0, live_q.size() - 1);
        off = live_q[k];
        live_q.delete(k);
      end
    end else if (pick < 85) begin
      kind = ($urandom_range(0, 1) != 0) ? REQ_INFO : REQ_INFO_ALT;
      if (live_q.size() != 0 && $urandom_range(0, 1) != 0) begin
        off = live_q[$urandom_range(0, live_q.size() - 1)];
      end
    end else begin
      kind = REQ_PUT;
      case ($urandom_range(0, 3))
        0: if (freed_q.size() != 0) off = freed_q[$urandom_range(0, freed_q.size() - 1)];
        1: if (live_q.size() != 0) begin
             off = live_q[$urandom_range(0, live_q.size() - 1)] ^ OFF_W'($urandom_range(1, 3));
           end
        2: off = OFF_W'($urandom_range(0, 80));
        default: ;
      endcase
    end
    send_request(kind, size, off, rep);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [SIZE_W-1:0] pool, input class_set_t sizes);
    write_reg(CFG_POOL_BYTES, pool);
    for (int i = 0; i < NUM_CLASSES; i++) write_reg(CFG_CLASS_SIZE_0 + CFG_IDX_W'(i), sizes[i]);
    cfg_valid_i <= 1'b0;
    cur_largest = sizes[0] & SIZE_MASK;
  endtask

  // Every request yields a reply, so the block is idle once none is due.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_settings(output logic [SIZE_W-1:0] pool, output class_set_t sizes);
    pool     = SIZE_W'($urandom_range(2048, 16384));
    sizes[0] = SIZE_W'($urandom_range(64, 4096));
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if ($urandom_range(0, 5) == 0) sizes[i] = '0;
      else sizes[i] = SIZE_W'(sizes[i-1] * $urandom_range(30, 95) / 100);
    end
  endtask

  initial begin : stimulus
    reply_t            r, g_small, g_big, g_mid;
    logic [SIZE_W-1:0] pool;
    class_set_t        sizes;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_GET;
    req_size_i      = '0;
    buffer_offset_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed checks on the reset settings.
    send_request(REQ_GET, 15'd0, 14'h3fff, g_small);
    send_request(REQ_GET, 15'd1024, 14'h0, g_big);
    send_request(REQ_GET, 15'd1025, 14'h0, r);
    send_request(REQ_GET, 15'h7fff, 14'h0, r);
    send_request(REQ_GET, 15'd17, 14'h0, g_mid);
    send_request(REQ_INFO, 15'h7fff, g_big.granted_offset, r);
    send_request(REQ_PUT, 15'd0, g_big.granted_offset, r);
    // A second put of the same buffer finds the descriptor already freed.
    send_request(REQ_PUT, 15'd0, g_big.granted_offset, r);
    send_request(REQ_INFO, 15'd0, g_big.granted_offset, r);
    send_request(REQ_GET, 15'd1000, 14'h0, r);
    send_request(REQ_PUT, 15'd0, g_small.granted_offset + 14'd2, r);
    send_request(REQ_PUT, 15'd0, 14'd0, r);
    send_request(REQ_PUT, 15'd0, 14'd15, r);
    send_request(REQ_PUT, 15'd0, 14'd16, r);
    send_request(REQ_PUT, 15'd0, 14'h3fff, r);
    send_request(REQ_INFO_ALT, 15'd0, g_mid.granted_offset, r);
    send_request(REQ_PUT, 15'd0, g_mid.granted_offset, r);
    send_request(REQ_PUT, 15'd0, g_small.granted_offset, r);
    send_request(REQ_GET, 15'd16, 14'h0, r);
    send_request(REQ_INFO, 15'd0, 14'h3fff, r);
    send_request(REQ_PUT, 15'h7fff, 14'h2000, r);

    for (int n = 0; n < 300; n++) begin
      if (n == 100) hold_req = 1'b1;
      random_request();
    end
    settle();

    // Oversized pool register, wide classes and a zero-size smallest class.
    apply_settings(15'h7fff, '{15'd16384, 15'd4096, 15'd2048, 15'd96, 15'd48, 15'd21, 15'd3});
    repeat (200) random_request();
    settle();

    apply_settings(15'd0, '{15'd1024, 15'd512, 15'd256, 15'd128, 15'd64, 15'd32, 15'd16});
    repeat (40) random_request();
    settle();

    apply_settings(15'd8003, '{15'h7fff, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0});
    repeat (60) random_request();
    settle();

    repeat (2) begin
      random_settings(pool, sizes);
      apply_settings(pool, sizes);
      repeat (200) random_request();
      settle();
    end

    // Smaller classes than many live buffers, so some puts carry an oversize tag.
    idle_en = 1'b0;
    apply_settings(15'd16384, '{15'd256, 15'd128, 15'd64, 15'd48, 15'd32, 15'd16, 15'd8});
    repeat (250) random_request();
    settle();

    if (sb.n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
